// File: rtl/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
`default_nettype none

package modexp_pkg;

	// Field widths fixed by the interface
	localparam int MOD_W = 31;
	localparam int EXP_W = 63;

	// Steps of one shift-add modular multiply, and the counter that tracks them
	localparam int MUL_STEPS = MOD_W;
	localparam int CNT_W     = $clog2(MUL_STEPS);

	// Modulus after reset
	localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_STEP,
		ST_MUL,
		ST_SQR,
		ST_FINISH
	} modexp_state_t;

	// Status of the shared multiply unit
	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

endpackage

`default_nettype wire

// File: rtl/modular_exponentiation.sv
// Modular exponentiation top level: sequencer around one shared modular multiplier.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one beat of operation, base_value
//   and exponent. Output channel (out_valid / out_stall) returns one beat of
//   power_result per input beat, in order. The user must write the modulus via
//   cfg_we / cfg_wdata only while idle (not enforced); it resets to 1000000007.
//   Operation 1 replaces the exponent by modulus - 2 (inverse for a prime).
// Schedule:
//   One item at a time. The base is first reduced, then each exponent bit
//   costs a step state plus a squaring, with a multiply before it on a set
//   bit, all on the one bit-serial unit. Scanning stops at the highest set
//   bit, a zero base or zero exponent ends early, and a zero or one modulus
//   answers 0 with no multiply.
// Reset and stall:
//   arst_n clears the sequencer and output valid at once. A finished result
//   sits in the output register while out_stall is high; the next input beat
//   is already taken then, and only its own finish waits for the register.
`default_nettype none

module modular_exponentiation
	import modexp_pkg::*;
#(
	parameter int EXP_BITS = 63
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [MOD_W-1:0] cfg_wdata,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             operation,
	input  wire logic [MOD_W-1:0] base_value,
	input  wire logic [EXP_W-1:0] exponent,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic      [MOD_W-1:0] power_result
);

	modexp_state_t state_q;
	modexp_state_t state_d;

	logic [MOD_W-1:0]    modulus_q;
	logic [EXP_BITS-1:0] exp_q;
	logic [MOD_W-1:0]    acc_q;
	logic [MOD_W-1:0]    sq_q;
	logic [MOD_W-1:0]    res_q;
	logic [MOD_W-1:0]    power_result_q;
	logic                out_valid_q;

	logic                mm_start;
	logic [MOD_W-1:0]    mm_x;
	logic [MOD_W-1:0]    mm_y;
	mm_stat_t            mm_stat;
	logic [MOD_W-1:0]    mm_product;

	logic                mod_small;
	logic                exp_zero;
	logic                exp_last;
	logic                out_load;
	logic [EXP_W-1:0]    inv_exp;

	assign mod_small = (modulus_q < MOD_W'(2));
	assign exp_zero  = (exp_q == '0);
	assign exp_last  = ((exp_q >> 1) == '0);
	assign inv_exp   = EXP_W'(modulus_q) - EXP_W'(2);

	// Shared modular multiplier
	modexp_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mm_start),
		.x       (mm_x),
		.y       (mm_y),
		.m       (modulus_q),
		.stat    (mm_stat),
		.product (mm_product)
	);

	// Modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_RESET;
		end else if (cfg_we) begin
			modulus_q <= cfg_wdata;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = mod_small ? ST_FINISH : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (mm_stat.done) begin
					state_d = (mm_product == '0) ? ST_FINISH : ST_STEP;
				end
			end
			ST_STEP: begin
				if (exp_zero) begin
					state_d = ST_FINISH;
				end else begin
					state_d = exp_q[0] ? ST_MUL : ST_SQR;
				end
			end
			ST_MUL: begin
				if (mm_stat.done) begin
					state_d = exp_last ? ST_FINISH : ST_SQR;
				end
			end
			ST_SQR: begin
				if (mm_stat.done) begin
					state_d = ST_STEP;
				end
			end
			ST_FINISH: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs: handshake and multiplier operands
	always_comb begin
		in_stall = 1'b1;
		mm_start = 1'b0;
		mm_x     = sq_q;
		mm_y     = sq_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				// Reduce the base as base * 1 mod m
				mm_start = in_valid && !mod_small;
				mm_x     = MOD_W'(1);
				mm_y     = base_value;
			end
			ST_STEP: begin
				mm_start = !exp_zero;
				mm_x     = exp_q[0] ? acc_q : sq_q;
			end
			ST_MUL: begin
				mm_start = mm_stat.done && !exp_last;
			end
			ST_FINISH: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Exponent, running product, square and result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					exp_q <= operation ? inv_exp[EXP_BITS-1:0] : exponent[EXP_BITS-1:0];
					res_q <= '0;
				end
			end
			ST_REDUCE: begin
				if (mm_stat.done) begin
					sq_q  <= mm_product;
					acc_q <= MOD_W'(1);
				end
			end
			ST_STEP: begin
				if (exp_zero) begin
					res_q <= acc_q;
				end
			end
			ST_MUL: begin
				if (mm_stat.done) begin
					acc_q <= mm_product;
					res_q <= mm_product;
				end
			end
			ST_SQR: begin
				if (mm_stat.done) begin
					sq_q  <= mm_product;
					exp_q <= exp_q >> 1;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	// Output register: hold while stalled, drop valid once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			power_result_q <= res_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign power_result = power_result_q;

	// The multiplier is never restarted while it is still working
	a_start_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		mm_start |-> !mm_stat.busy)
		else $error("multiplier started while busy");

	// Waiting states always have a multiply in flight or just finished
	a_wait_has_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REDUCE || state_q == ST_MUL || state_q == ST_SQR)
		|-> (mm_stat.busy || mm_stat.done))
		else $error("sequencer waits on an idle multiplier");

	// A delivered result is zero or reduced below the modulus
	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (res_q < modulus_q || res_q == '0))
		else $error("result not reduced");

endmodule

`default_nettype wire

// File: rtl/modexp_mulmod.sv
// Bit-serial modular multiplier: product = (x * y) mod m, one bit of y per cycle.
`default_nettype none

module modexp_mulmod
	import modexp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [MOD_W-1:0] x,
	input  wire logic [MOD_W-1:0] y,
	input  wire logic [MOD_W-1:0] m,
	output mm_stat_t              stat,
	output logic      [MOD_W-1:0] product
);

	logic [MOD_W-1:0] acc_q;
	logic [MOD_W-1:0] x_q;
	logic [MOD_W-1:0] y_q;
	logic [MOD_W-1:0] m_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [MOD_W+2:0] sum;
	logic [MOD_W+2:0] sub1;
	logic [MOD_W+2:0] sub2;
	logic [MOD_W+2:0] mod1;
	logic [MOD_W+2:0] mod2;
	logic [MOD_W-1:0] acc_next;

	// Double the partial product, add x on a set bit, then fold back below m
	always_comb begin
		sum  = {2'b00, acc_q, 1'b0} + (y_q[MOD_W-1] ? {3'b000, x_q} : '0);
		mod1 = {3'b000, m_q};
		mod2 = {2'b00, m_q, 1'b0};
		sub1 = sum - mod1;
		sub2 = sum - mod2;
		if (sum >= mod2) begin
			acc_next = sub2[MOD_W-1:0];
		end else if (sum >= mod1) begin
			acc_next = sub1[MOD_W-1:0];
		end else begin
			acc_next = sum[MOD_W-1:0];
		end
	end

	// Control: count steps, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operands and partial product
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
			m_q   <= m;
		end else if (busy_q) begin
			acc_q <= acc_next;
			y_q   <= {y_q[MOD_W-2:0], 1'b0};
		end
	end

	assign stat    = '{busy: busy_q, done: done_q};
	assign product = acc_q;

	// Done is a single-cycle pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !start |=> !done_q)
		else $error("multiply done held longer than one cycle");

	// A finished product is reduced below the modulus
	a_done_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (acc_q < m_q))
		else $error("multiply product not reduced");

endmodule

`default_nettype wire

// File: sim/tb_modular_exponentiation.sv
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 100ps

module tb_modular_exponentiation;
	import modexp_pkg::*;

	localparam int EXP_BITS      = 63;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_AT       = 30;
	localparam int HOLD_CYCLES   = 3000;
	localparam int IDLE_LIMIT    = 20000;
	localparam int REPORT_MAX    = 10;

	localparam logic OP_POWER   = 1'b0;
	localparam logic OP_INVERSE = 1'b1;

	localparam logic [EXP_W-1:0] EXP_ONES = 63'h7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic             op;
		logic [MOD_W-1:0] base;
		logic [EXP_W-1:0] expo;
		logic             typed;
		logic [MOD_W-1:0] want;
	} probe_row_t;

	// Directed beats; a typed row carries its own expected power
	localparam int N_ROWS = 19;
	probe_row_t probe_rows [N_ROWS] = '{
		'{OP_POWER,   31'd0,          63'd0,                   1'b1, 31'd0},
		'{OP_POWER,   31'd5,          63'd0,                   1'b1, 31'd1},
		'{OP_POWER,   31'd1000000007, 63'd5,                   1'b1, 31'd0},
		'{OP_POWER,   31'd2000000014, 63'd0,                   1'b1, 31'd0},
		'{OP_POWER,   31'h7FFF_FFFF,  63'd1,                   1'b1, 31'd147483633},
		'{OP_POWER,   31'd3,          63'd1,                   1'b1, 31'd3},
		'{OP_POWER,   31'd2,          63'd10,                  1'b1, 31'd1024},
		'{OP_POWER,   31'd1,          EXP_ONES,                1'b1, 31'd1},
		'{OP_POWER,   31'd1000000008, 63'h0123_4567_89AB_CDEF, 1'b1, 31'd1},
		'{OP_POWER,   31'd1000000006, 63'd2,                   1'b1, 31'd1},
		'{OP_INVERSE, 31'd0,          63'd0,                   1'b1, 31'd0},
		'{OP_INVERSE, 31'd1,          63'd0,                   1'b1, 31'd1},
		'{OP_INVERSE, 31'd1000000006, EXP_ONES,                1'b1, 31'd1000000006},
		'{OP_POWER,   31'h7FFF_FFFF,  EXP_ONES,                1'b0, 31'd0},
		'{OP_POWER,   31'd2,          63'h4000_0000_0000_0000, 1'b0, 31'd0},
		'{OP_POWER,   31'd12345,      63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 31'd0},
		'{OP_POWER,   31'h5555_5555,  63'h5555_5555_5555_5555, 1'b0, 31'd0},
		'{OP_INVERSE, 31'd2,          63'd0,                   1'b0, 31'd0},
		'{OP_INVERSE, 31'h7FFF_FFFF,  EXP_ONES,                1'b0, 31'd0}
	};

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             cfg_we     = 1'b0;
	logic [MOD_W-1:0] cfg_wdata  = '0;
	logic             in_valid   = 1'b0;
	logic             in_stall;
	logic             operation  = OP_POWER;
	logic [MOD_W-1:0] base_value = '0;
	logic [EXP_W-1:0] exponent   = '0;
	logic             out_valid;
	logic             out_stall  = 1'b0;
	logic [MOD_W-1:0] power_result;

	logic [MOD_W-1:0] power_due [$];
	logic [MOD_W-1:0] modulus_now = MOD_RESET;
	int               burst_left  = 0;
	int               err_count   = 0;
	int               results_taken = 0;
	int               items_sent  = 0;
	int               inverse_sent = 0;
	int               zero_base_sent = 0;
	int               settings_run = 1;
	int               idle_cycles = 0;
	logic             long_hold_done = 1'b0;

	modular_exponentiation #(
		.EXP_BITS(EXP_BITS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.base_value  (base_value),
		.exponent    (exponent),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.power_result(power_result)
	);

	always #5 clk = ~clk;

	// Square-and-multiply from the low exponent bit, base reduced first
	function automatic logic [MOD_W-1:0] predict_power(input logic op,
			input logic [MOD_W-1:0] b, input logic [EXP_W-1:0] e,
			input logic [MOD_W-1:0] m);
		logic [63:0]      acc;
		logic [63:0]      sq;
		logic [63:0]      mm;
		logic [EXP_W-1:0] ex;
		mm = {33'd0, m};
		if (m < 31'd2)
			return '0;
		ex = (op == OP_INVERSE) ? {32'd0, m - 31'd2} : e;
		sq = {33'd0, b} % mm;
		if (sq == 64'd0)
			return '0;
		acc = 64'd1;
		for (int i = 0; i < EXP_BITS; i++) begin
			if (ex[i])
				acc = (acc * sq) % mm;
			sq = (sq * sq) % mm;
		end
		return acc[MOD_W-1:0];
	endfunction

	// Offer one beat in bursts with random gaps; record the expected power on accept
	task automatic offer_beat(input logic op, input logic [MOD_W-1:0] b,
			input logic [EXP_W-1:0] e, input logic typed, input logic [MOD_W-1:0] want);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		in_valid   <= 1'b1;
		operation  <= op;
		base_value <= b;
		exponent   <= e;
		do @(posedge clk); while (in_stall);
		power_due = {power_due, (typed ? want : predict_power(op, b, e, modulus_now))};
		items_sent++;
		if (op == OP_INVERSE)
			inverse_sent++;
		if (b == '0)
			zero_base_sent++;
	endtask

	// Drop valid, wait for every pending power, then let the block settle
	task automatic drain_block();
		in_valid <= 1'b0;
		burst_left = 0;
		while (power_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_modulus(input logic [MOD_W-1:0] m);
		drain_block();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		modulus_now = m;
		settings_run++;
	endtask

	task automatic report_miss(input string what, input logic [MOD_W-1:0] want,
			input logic [MOD_W-1:0] got);
		err_count++;
		if (err_count <= REPORT_MAX)
			$display("%t: %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// Check each output beat against the oldest pending power
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_taken++;
			if (power_due.size() == 0)
				report_miss("power beat with nothing pending", '0, power_result);
			else if (power_due[0] !== power_result)
				report_miss("power mismatch", power_due.pop_front(), power_result);
			else
				void'(power_due.pop_front());
		end
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles, %0d powers pending",
				idle_cycles, power_due.size());
			$display("tb_modular_exponentiation: errors");
			$finish;
		end
	end

	// Output pacing: random stall modes, plus one long hold to back up the input
	initial begin : rx_pacing
		int span_left;
		int mode;
		span_left = 0;
		mode      = 0;
		@(posedge clk);
		forever begin
			if (!long_hold_done && results_taken >= HOLD_AT) begin
				long_hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (span_left == 0) begin
				mode      = $urandom_range(0, 3);
				span_left = $urandom_range(16, 96);
			end
			span_left--;
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 1) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ~out_stall;
			endcase
			@(posedge clk);
		end
	end

	initial begin : stimulus
		logic [MOD_W-1:0] mod_plan [9];
		logic [MOD_W-1:0] b;
		logic [EXP_W-1:0] e;
		logic [63:0]      r64;
		logic [31:0]      r32;
		logic             op;
		int               n_items;
		int               width;
		int               k;

		mod_plan = '{31'd2, 31'd3, 31'h7FFF_FFFF, 31'd65537, 31'd0, 31'd1, 31'd0,
			31'd1000, MOD_RESET};
		r32 = $urandom_range(2, 32'h7FFF_FFFF);
		mod_plan[6] = r32[MOD_W-1:0];

		// Hold reset, then release
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats under the reset modulus
		for (int i = 0; i < N_ROWS; i++)
			offer_beat(probe_rows[i].op, probe_rows[i].base, probe_rows[i].expo,
				probe_rows[i].typed, probe_rows[i].want);

		// Random beats, one phase per modulus setting
		foreach (mod_plan[p]) begin
			load_modulus(mod_plan[p]);
			n_items = (mod_plan[p] < 31'd2) ? 6 : 16;
			for (int n = 0; n < n_items; n++) begin
				op = ($urandom_range(0, 3) == 0) ? OP_INVERSE : OP_POWER;

				case ($urandom_range(0, 7))
					0: b = '0;
					1: begin
						if (modulus_now == '0) begin
							b = '0;
						end else begin
							k   = $urandom_range(1, 32'h7FFF_FFFF / {1'b0, modulus_now});
							r32 = {1'b0, modulus_now} * k;
							b   = r32[MOD_W-1:0];
						end
					end
					2: b = modulus_now - 31'd1;
					default: begin
						r32 = $urandom;
						b   = r32[MOD_W-1:0];
					end
				endcase

				// Mostly short exponents keep latency low; a few span all bits
				r64 = {$urandom, $urandom};
				case ($urandom_range(0, 9))
					0: e = '0;
					1: e = r64[EXP_W-1:0];
					default: begin
						width = $urandom_range(1, 20);
						r64   = r64 & ((64'd1 << width) - 64'd1);
						e     = r64[EXP_W-1:0];
					end
				endcase

				offer_beat(op, b, e, 1'b0, '0);
			end
		end

		drain_block();
		$display("covered %0d beats (%0d inverse, %0d zero base) over %0d modulus settings",
			items_sent, inverse_sent, zero_base_sent, settings_run);
		$display("checked %0d powers, %0d mismatches", results_taken, err_count);
		if (err_count == 0)
			$display("tb_modular_exponentiation: clean");
		else
			$display("tb_modular_exponentiation: errors");
		$finish;
	end

endmodule

// File: modular_exponentiation.f
rtl/modexp_pkg.sv
rtl/modexp_mulmod.sv
rtl/modular_exponentiation.sv
sim/tb_modular_exponentiation.sv
